// File: sv/fully_assoc_cache_lru_fifo_assert.svh
// Assertion macros shared by the cache tag model RTL.
// Uses the including module's clk and rst_n; no other dependencies.
`ifndef FULLY_ASSOC_CACHE_LRU_FIFO_ASSERT_SVH
`define FULLY_ASSOC_CACHE_LRU_FIFO_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge out of reset.
`define FAC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fac assertion failed");
// Next-cycle implication.
`define FAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fac assertion failed");
`else
`define FAC_ASSERT_IMPL(label, ante, cons)
`define FAC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: sv/fac_pkg.sv
// Shared types and constants for the fully associative cache tag model.
// No dependencies; imported by fac_cell and the top level.
`timescale 1ns / 1ps
package fac_pkg;

    // register index, taken from paddr[2]
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_WAYS   = 1'b1;

    localparam logic POLICY_LRU  = 1'b0;
    localparam logic POLICY_FIFO = 1'b1;

    localparam int        WAYS_CFG_W = 4;
    localparam logic [3:0] WAYS_RESET = 4'd8;

    // seen bitmap is stored as rows of eight bits
    localparam int SEEN_ROW_W = 8;
    localparam int SEEN_SEL_W = 3;

    typedef struct packed {
        logic shift;   // take the neighbor's entry this cycle
        logic in_use;  // entry position lies below ways_in_use
    } cell_ctrl_t;

endpackage

// File: sv/fac_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module fac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/fac_cell.sv
// One entry of the recency-ordered tag chain: tag, valid, match and priority.
// Depends on fac_pkg.
`timescale 1ns / 1ps
module fac_cell import fac_pkg::*; #(
    parameter int ADDR_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  logic                  prev_valid,
    input  logic [ADDR_WIDTH-1:0] prev_tag,
    input  logic [ADDR_WIDTH-1:0] lookup_addr,
    input  logic                  match_before,
    output logic                  valid,
    output logic [ADDR_WIDTH-1:0] tag,
    output logic                  match_chain
);

    logic                  valid_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    logic                  match_here;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            tag_reg <= prev_tag;
        end
    end

    assign match_here  = valid_reg & ctrl.in_use & (tag_reg == lookup_addr);
    // any newer cell matching already wins
    assign match_chain = match_before | match_here;
    assign valid       = valid_reg;
    assign tag         = tag_reg;

endmodule

// File: sv/fully_assoc_cache_lru_fifo.sv
// Top level of the fully associative cache tag model (LRU or FIFO replacement).
// Depends on fac_pkg, fac_cell, fac_ram and fully_assoc_cache_lru_fifo_assert.svh.
//
// For each access, start is taken when busy is low, the seen-bitmap row is
// read on that edge, and in the following cycle the tag chain is compared,
// updated and the row is written back; the result beat (done with hit and
// compulsory_miss) shows in the cycle after that and busy drops in the same
// cycle. Busy is high through the lookup, so the read-modify-write on the
// single seen-bitmap memory ends before a new access can be taken.
// The receiver cannot stall: every result beat is on the ports for exactly
// one cycle and must be taken then. After reset the seen bitmap is swept
// clear one row of eight addresses a cycle, all 2^(ADDR_WIDTH-3) rows (8192
// at the default width), with busy held high; configuration writes over the
// APB port are taken during the sweep and at any time the block is idle.
`timescale 1ns / 1ps
`include "fully_assoc_cache_lru_fifo_assert.svh"
module fully_assoc_cache_lru_fifo import fac_pkg::*; #(
    parameter int WAYS       = 8,
    parameter int ADDR_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // access command
    input  logic                  start,
    output logic                  busy,
    input  logic [ADDR_WIDTH-1:0] access_address,
    // result beat
    output logic                  done,
    output logic                  hit,
    output logic                  compulsory_miss
);

    localparam int ROW_AW     = ADDR_WIDTH - SEEN_SEL_W;
    localparam int ROWS       = 1 << ROW_AW;
    localparam int WAYS_CLAMP = (WAYS < 15) ? WAYS : 15;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic                  policy_reg;
    logic [WAYS_CFG_W-1:0] ways_reg;
    logic [WAYS_CFG_W-1:0] ways_eff;
    logic                  cfg_write;

    logic [ROW_AW-1:0]     clr_cnt_reg;
    logic [ADDR_WIDTH-1:0] addr_reg;
    logic                  accept;
    logic                  lookup;

    logic                  done_reg, hit_reg, comp_reg;

    cell_ctrl_t            ctrl [WAYS];
    logic [WAYS:0]         match_prev;
    logic [WAYS-1:0]       valid_vec;
    logic [ADDR_WIDTH-1:0] tag_vec [WAYS];
    logic                  hit_any;

    logic [SEEN_ROW_W-1:0] seen_row;
    logic [SEEN_ROW_W-1:0] seen_mask;
    logic                  seen;
    logic                  ram_we;
    logic [ROW_AW-1:0]     ram_waddr;
    logic [SEEN_ROW_W-1:0] ram_wdata;

    // ---------------------------------------------------------------
    // Configuration registers: policy at 0x0, ways_in_use at 0x4
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_LRU;
            ways_reg   <= WAYS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_POLICY: policy_reg <= pwdata[0];
                REG_WAYS:   ways_reg   <= pwdata[WAYS_CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_POLICY: prdata = {31'b0, policy_reg};
            REG_WAYS:   prdata = {{(32-WAYS_CFG_W){1'b0}}, ways_reg};
            default:    prdata = '0;
        endcase
    end

    // Zero acts as one way; anything above the built ways acts as all of them.
    always_comb
    begin
        if (ways_reg == '0)
        begin
            ways_eff = WAYS_CFG_W'(1);
        end
        else if (32'(ways_reg) > WAYS_CLAMP)
        begin
            ways_eff = WAYS_CFG_W'(WAYS_CLAMP);
        end
        else
        begin
            ways_eff = ways_reg;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: sweep the bitmap, then alternate idle and lookup
    // ---------------------------------------------------------------
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start & ~busy;
    assign lookup = (state_reg == ST_LOOKUP);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (&clr_cnt_reg) state_next = ST_IDLE;
            ST_IDLE:   if (start)        state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ROW_AW'(1);
            end
        end
    end

    // hold the address of the beat in flight
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= access_address;
        end
    end

    // ---------------------------------------------------------------
    // Tag chain: cell 0 is the newest entry, position equals age rank.
    // A miss pushes the address in at cell 0 and drops the last cell;
    // an LRU hit at cell h pushes it in and advances cells 0..h only.
    // ---------------------------------------------------------------
    assign match_prev[0] = 1'b0;
    assign hit_any       = match_prev[WAYS];

    for (genvar i = 0; i < WAYS; i++)
    begin : g_cell
        logic                  in_valid;
        logic [ADDR_WIDTH-1:0] in_tag;

        if (i == 0)
        begin : g_head
            assign in_valid = 1'b1;
            assign in_tag   = addr_reg;
        end
        else
        begin : g_link
            assign in_valid = valid_vec[i-1];
            assign in_tag   = tag_vec[i-1];
        end

        assign ctrl[i].in_use = (32'(ways_eff) > i);
        assign ctrl[i].shift  = lookup &
            ~(hit_any & ((policy_reg == POLICY_FIFO) | match_prev[i]));

        fac_cell #(
            .ADDR_WIDTH (ADDR_WIDTH)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl[i]),
            .prev_valid   (in_valid),
            .prev_tag     (in_tag),
            .lookup_addr  (addr_reg),
            .match_before (match_prev[i]),
            .valid        (valid_vec[i]),
            .tag          (tag_vec[i]),
            .match_chain  (match_prev[i+1])
        );
    end

    // ---------------------------------------------------------------
    // Seen bitmap: read on accept, write back the set bit in lookup
    // ---------------------------------------------------------------
    assign seen_mask = SEEN_ROW_W'(1) << addr_reg[SEEN_SEL_W-1:0];
    assign seen      = seen_row[addr_reg[SEEN_SEL_W-1:0]];
    assign ram_we    = (state_reg == ST_CLEAR) | lookup;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg
                                               : addr_reg[ADDR_WIDTH-1:SEEN_SEL_W];
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : (seen_row | seen_mask);

    fac_ram #(
        .WIDTH (SEEN_ROW_W),
        .DEPTH (ROWS)
    ) u_seen_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (access_address[ADDR_WIDTH-1:SEEN_SEL_W]),
        .rdata (seen_row)
    );

    // ---------------------------------------------------------------
    // Result beat, registered for one cycle
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= lookup;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lookup)
        begin
            hit_reg  <= hit_any;
            comp_reg <= ~hit_any & ~seen;
        end
    end

    assign done            = done_reg;
    assign hit             = hit_reg;
    assign compulsory_miss = comp_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `FAC_ASSERT_NEXT(a_accept_busy, accept, busy)
    `FAC_ASSERT_NEXT(a_lookup_done, lookup, done)
    `FAC_ASSERT_IMPL(a_done_from_lookup, done, $past(lookup))
    `FAC_ASSERT_IMPL(a_hit_not_comp, done, !(hit && compulsory_miss))
    `FAC_ASSERT_IMPL(a_valid_packed, 1'b1, (valid_vec & (valid_vec + WAYS'(1))) == '0)

endmodule

// File: test/fully_assoc_cache_lru_fifo_test.sv
// Self-checking testbench for the fully associative cache tag model (LRU / FIFO).
// Drives access commands and APB register writes and predicts each hit/miss beat.
// Depends on fac_pkg and the fully_assoc_cache_lru_fifo top level only.
`timescale 1ns / 1ps
module fully_assoc_cache_lru_fifo_test import fac_pkg::*;;

    localparam int WAYS           = 8;
    localparam int ADDR_W         = 16;
    // The post-reset seen-bitmap sweep alone runs with no accepted beat.
    localparam int WATCHDOG_LIMIT = 30000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 85;

    typedef struct packed {
        logic hit;
        logic compulsory_miss;
    } access_outcome_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              start = 1'b0;
    logic              busy;
    logic [ADDR_W-1:0] access_address = '0;
    logic              done;
    logic              hit;
    logic              compulsory_miss;

    fully_assoc_cache_lru_fifo #(
        .WAYS       (WAYS),
        .ADDR_WIDTH (ADDR_W)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .start           (start),
        .busy            (busy),
        .access_address  (access_address),
        .done            (done),
        .hit             (hit),
        .compulsory_miss (compulsory_miss)
    );

    // Shadow copy of the cache: tags, valid bits, age ranks (0 newest), seen bitmap.
    logic [ADDR_W-1:0] line_tag   [WAYS];
    logic              line_valid [WAYS];
    int                line_rank  [WAYS];
    bit                addr_seen  [0:(1 << ADDR_W) - 1];
    logic              model_policy = POLICY_LRU;
    logic [3:0]        model_ways   = WAYS_RESET;

    access_outcome_t   pending_outcomes [$];
    int                mismatch_count = 0;
    int                quiet_cycles = 0;
    bit                idle_enabled = 1'b1;
    logic [ADDR_W-1:0] last_address = '0;

    // Address pool for the random phases; small pools make hits likely.
    logic [ADDR_W-1:0] hot_pool [16];
    int                pool_size = 8;

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            line_tag[i]   = '0;
            line_valid[i] = 1'b0;
            line_rank[i]  = 0;
        end
    end

    // Predict one access and advance the shadow state exactly as the block should.
    function automatic access_outcome_t predict_access(input logic [ADDR_W-1:0] addr);
        access_outcome_t res;
        int n;
        int found;
        int best;
        int victim;
        int i;
        bit was_seen;
        n = (model_ways == 0) ? 1 : ((model_ways > WAYS) ? WAYS : int'(model_ways));
        found = -1;
        best = 0;
        // Only entries ranked below the ways in use may hit; the newest match wins.
        for (i = 0; i < WAYS; i++)
        begin
            if (line_valid[i] && line_rank[i] < n && line_tag[i] == addr)
            begin
                if (found < 0 || line_rank[i] < best)
                begin
                    found = i;
                    best = line_rank[i];
                end
            end
        end
        was_seen = addr_seen[addr];
        addr_seen[addr] = 1'b1;
        if (found >= 0)
        begin
            // LRU promotes the hit entry; FIFO leaves the order alone.
            if (model_policy == POLICY_LRU)
            begin
                for (i = 0; i < WAYS; i++)
                begin
                    if (line_valid[i] && line_rank[i] < best)
                        line_rank[i]++;
                end
                line_rank[found] = 0;
            end
            res.hit = 1'b1;
            res.compulsory_miss = 1'b0;
            return res;
        end
        // Miss: take the lowest invalid entry, else the oldest one.
        victim = -1;
        for (i = 0; i < WAYS && victim < 0; i++)
        begin
            if (!line_valid[i])
                victim = i;
        end
        if (victim < 0)
        begin
            for (i = 0; i < WAYS; i++)
            begin
                if (line_rank[i] == WAYS - 1)
                    victim = i;
            end
            if (victim < 0)
                victim = 0;
        end
        for (i = 0; i < WAYS; i++)
        begin
            if (i != victim && line_valid[i])
                line_rank[i]++;
        end
        line_tag[victim]   = addr;
        line_valid[victim] = 1'b1;
        line_rank[victim]  = 0;
        res.hit = 1'b0;
        res.compulsory_miss = !was_seen;
        return res;
    endfunction

    // Send one access beat. Start is dropped at the accepting edge, so the next call
    // waits on the clock before raising it again; busy is high during that wait anyway.
    task automatic send_access(input logic [ADDR_W-1:0] addr);
        @(posedge clk);
        while (idle_enabled && $urandom_range(0, 99) < 24)
        begin
            // Toggle the address bus while idle; it must be ignored.
            access_address <= ADDR_W'($urandom);
            @(posedge clk);
        end
        start <= 1'b1;
        access_address <= addr;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        start <= 1'b0;
        last_address = addr;
        pending_outcomes.push_back(predict_access(addr));
    endtask

    // Hold until every predicted beat has been checked.
    task automatic wait_results_drained();
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic reg_index, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Bits above each register's width are dropped.
        if (reg_index == REG_POLICY)
            model_policy = value[0];
        else
            model_ways = value[3:0];
    endtask

    // Reprogram both registers once the block is idle; upper data bits carry noise.
    task automatic set_mode(input logic pol, input logic [3:0] ways_val);
        logic [31:0] noise;
        wait_results_drained();
        noise = $urandom;
        apb_write(REG_POLICY, {noise[31:1], pol});
        noise = $urandom;
        apb_write(REG_WAYS, {noise[31:4], ways_val});
    endtask

    // Check every result beat against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result beat with no access outstanding: hit %b compulsory_miss %b",
                       hit, compulsory_miss);
                mismatch_count++;
            end
            else
            begin
                access_outcome_t exp_out;
                exp_out = pending_outcomes.pop_front();
                if (hit !== exp_out.hit)
                begin
                    $error("hit: expected %b, got %b", exp_out.hit, hit);
                    mismatch_count++;
                end
                if (compulsory_miss !== exp_out.compulsory_miss)
                begin
                    $error("compulsory_miss: expected %b, got %b",
                           exp_out.compulsory_miss, compulsory_miss);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles without any accepted beat.
    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Cold misses on both address extremes, hits, then fill past capacity so the
    // least recently used line goes, and touch it again for a capacity miss.
    task automatic test_lru_fill_and_evict();
        set_mode(POLICY_LRU, 4'd8);
        send_access(16'h0000);
        send_access(16'hFFFF);
        send_access(16'h0000);
        send_access(16'hFFFF);
        send_access(16'h0000);
        for (int i = 0; i < 7; i++)
            send_access(16'h1000 + 16'(i));
        send_access(16'hFFFF);
    endtask

    // FIFO: a hit on the oldest line does not save it from the next eviction.
    task automatic test_fifo_keeps_order();
        set_mode(POLICY_FIFO, 4'd8);
        send_access(16'hFFFF);
        send_access(16'h1000);
        send_access(16'h2AAA);
        send_access(16'h1000);
    endtask

    // Ways out of range and lines parked beyond the ways in use.
    task automatic test_partial_ways();
        // Zero ways acts as one: only the newest line can hit.
        set_mode(POLICY_LRU, 4'd0);
        send_access(last_address);
        send_access(16'h1004);
        // Two ways: a line ranked deeper misses and gets a second, newest copy.
        set_mode(POLICY_LRU, 4'd2);
        send_access(16'h1005);
        send_access(16'h1002);
        // Above the built count acts as all ways; duplicates resolve to the newest.
        set_mode(POLICY_FIFO, 4'd15);
        send_access(16'h1002);
        send_access(16'h1004);
    endtask

    // Random traffic over several register settings, extremes first.
    task automatic test_random_traffic();
        logic       pol;
        logic [3:0] ways_val;
        int         pick;
        logic [ADDR_W-1:0] addr;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    pol      = POLICY_LRU;
                    ways_val = 4'd1;
                end
                1:
                begin
                    pol      = POLICY_FIFO;
                    ways_val = 4'd8;
                end
                2:
                begin
                    pol      = POLICY_LRU;
                    ways_val = 4'd8;
                end
                3:
                begin
                    pol      = POLICY_FIFO;
                    ways_val = 4'd1;
                end
                default:
                begin
                    pol = 1'($urandom);
                    ways_val = 4'($urandom_range(0, 15));
                end
            endcase
            set_mode(pol, ways_val);
            // Refresh part of the hot pool; keep the rest to reuse cached lines.
            pool_size = $urandom_range(3, 16);
            for (int i = 0; i < 16; i++)
            begin
                if (phase == 0 || $urandom_range(0, 1) == 0)
                    hot_pool[i] = ADDR_W'($urandom);
            end
            // One phase runs back to back with no idle cycles.
            idle_enabled = (phase != 5);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    addr = hot_pool[$urandom_range(0, pool_size - 1)];
                else if (pick < 80)
                    addr = last_address;
                else
                    addr = ADDR_W'($urandom);
                // Pause once per phase until all outstanding beats are back.
                if (n == PHASE_ITEMS / 2)
                    wait_results_drained();
                send_access(addr);
            end
        end
        idle_enabled = 1'b1;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_lru_fill_and_evict();
        test_fifo_keeps_order();
        test_partial_ways();
        test_random_traffic();
        wait_results_drained();
        // Give a stray late beat a chance to show up.
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
